@@ src/nsd_pkg.sv @@
// Shared constants, request/status codes, control structs and name helpers
// for the named store directory. No dependencies.
package nsd_pkg;

   localparam int ENTRIES     = 16;
   localparam int IDX_W       = $clog2(ENTRIES);
   localparam int NAME_CHARS  = 8;
   localparam int KEY_W       = 64;
   localparam int STORE_BYTES = 4096;
   localparam int ADDR_W      = 12;
   localparam int SIZE_W      = 13;
   localparam int SEL_W       = 8;
   localparam int CNT_W       = 5;
   localparam int SUM_W       = 15;

   localparam logic [2:0] OP_GET      = 3'd0;
   localparam logic [2:0] OP_SET      = 3'd1;
   localparam logic [2:0] OP_DEL_VAR  = 3'd2;
   localparam logic [2:0] OP_DEL_APP  = 3'd3;
   localparam logic [2:0] OP_ERASE    = 3'd4;
   localparam logic [2:0] OP_ENUM     = 3'd5;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BOGUS     = 3'd1;
   localparam logic [2:0] ST_TOO_LARGE = 3'd2;
   localparam logic [2:0] ST_NO_SPACE  = 3'd3;
   localparam logic [2:0] ST_NO_ENTRY  = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND = 3'd5;
   localparam logic [2:0] ST_RANGE     = 3'd6;

   typedef struct packed {
      logic             load;
      logic [IDX_W-1:0] idx;
      logic             find_step;
      logic             fit_init;
      logic             fit_step;
      logic             del_step;
      logic             write_new;
      logic             erase;
      logic             finish;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       hit;
      logic       need_zero;
      logic       no_space;
      logic       moved;
      logic       free_found;
   } stat_type;

   function automatic logic [7:0] to_lower(input logic [7:0] x);
      to_lower = (x >= 8'h41 && x <= 8'h5A) ? x + 8'd32 : x;
   endfunction

   function automatic logic names_match(input logic [KEY_W-1:0] a,
                                        input logic [KEY_W-1:0] b);
      logic       ok;
      logic       stop;
      logic [7:0] x;
      logic [7:0] y;
      ok   = 1'b1;
      stop = 1'b0;
      for (int c = 0; c < NAME_CHARS; c++) begin
         x = to_lower(a[8*c +: 8]);
         y = to_lower(b[8*c +: 8]);
         if (!stop) begin
            if (x != y) begin
               ok   = 1'b0;
               stop = 1'b1;
            end else if (x == 8'd0) begin
               stop = 1'b1;
            end
         end
      end
      names_match = ok;
   endfunction

   function automatic logic [KEY_W-1:0] trim_name(input logic [KEY_W-1:0] a);
      logic [KEY_W-1:0] r;
      logic             stop;
      r    = '0;
      stop = 1'b0;
      for (int c = 0; c < NAME_CHARS; c++) begin
         if (a[8*c +: 8] == 8'd0) stop = 1'b1;
         if (!stop) r[8*c +: 8] = a[8*c +: 8];
      end
      trim_name = r;
   endfunction

endpackage

@@ src/nsd_ctrl.sv @@
// Controller state machine for the named store directory: sequences the
// entry scans and first-fit passes. Depends on nsd_pkg.
module nsd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [nsd_pkg::SEL_W-1:0] req_entry_select,
   input  nsd_pkg::stat_type   stat,
   output nsd_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_strobe
);
   import nsd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DISPATCH, S_FIND, S_FIND_DONE, S_FIT, S_FIT_END, S_DEL, S_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             busy_ff, strobe_ff;
   logic             last;

   assign last = (idx_ff == IDX_W'(ENTRIES - 1));

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.idx  = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               idx_in   = req_entry_select[IDX_W-1:0];
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.op == OP_GET || stat.op == OP_SET) begin
               idx_in   = '0;
               state_in = S_FIND;
            end else if (stat.op == OP_DEL_VAR || stat.op == OP_DEL_APP) begin
               idx_in   = '0;
               state_in = S_DEL;
            end else begin
               cmd.erase = (stat.op == OP_ERASE);
               state_in  = S_FINISH;
            end
         end
         S_FIND: begin
            cmd.find_step = 1'b1;
            idx_in        = idx_ff + 1'b1;
            if (last) state_in = S_FIND_DONE;
         end
         S_FIND_DONE: begin
            if (stat.hit || stat.op == OP_GET || stat.need_zero) begin
               state_in = S_FINISH;
            end else begin
               cmd.fit_init = 1'b1;
               idx_in       = '0;
               state_in     = S_FIT;
            end
         end
         S_FIT: begin
            cmd.fit_step = 1'b1;
            idx_in       = idx_ff + 1'b1;
            if (last) state_in = S_FIT_END;
         end
         S_FIT_END: begin
            if (stat.no_space) begin
               state_in = S_FINISH;
            end else if (stat.moved) begin
               cmd.fit_init = 1'b1;
               idx_in       = '0;
               state_in     = S_FIT;
            end else begin
               cmd.write_new = stat.free_found;
               state_in      = S_FINISH;
            end
         end
         S_DEL: begin
            cmd.del_step = 1'b1;
            idx_in       = idx_ff + 1'b1;
            if (last) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         idx_ff    <= '0;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         busy_ff   <= (state_in != S_IDLE);
         strobe_ff <= (state_ff == S_FINISH);
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

`ifndef SYNTH
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("result while busy");
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("repeated result");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request not taken");
`endif

endmodule

@@ src/nsd_dpath.sv @@
// Datapath of the named store directory: entry table, name match, first-fit
// search and result formation. Depends on nsd_pkg.
module nsd_dpath (
   input  logic                       clock,
   input  logic                       reset,
   input  nsd_pkg::cmd_type           cmd,
   output nsd_pkg::stat_type          stat,
   input  logic [2:0]                 req_opcode,
   input  logic [nsd_pkg::KEY_W-1:0]  req_app_key,
   input  logic [nsd_pkg::KEY_W-1:0]  req_var_key,
   input  logic [nsd_pkg::SIZE_W-1:0] req_write_len,
   input  logic [nsd_pkg::SIZE_W-1:0] req_write_skip,
   input  logic [nsd_pkg::SEL_W-1:0]  req_entry_select,
   output logic [2:0]                 rsp_status,
   output logic [nsd_pkg::ADDR_W-1:0] rsp_byte_address,
   output logic [nsd_pkg::SIZE_W-1:0] rsp_length,
   output logic [nsd_pkg::CNT_W-1:0]  rsp_deleted_count,
   output logic [nsd_pkg::IDX_W-1:0]  rsp_entry_number,
   output logic [nsd_pkg::KEY_W-1:0]  rsp_app_key_out,
   output logic [nsd_pkg::KEY_W-1:0]  rsp_var_key_out
);
   import nsd_pkg::*;

   logic [KEY_W-1:0]  app_mem  [ENTRIES];
   logic [KEY_W-1:0]  var_mem  [ENTRIES];
   logic [ADDR_W-1:0] base_mem [ENTRIES];
   logic [SIZE_W-1:0] size_mem [ENTRIES];

   logic [2:0]        op_ff;
   logic [KEY_W-1:0]  app_ff, var_ff;
   logic [SIZE_W-1:0] len_ff, skip_ff;
   logic [SEL_W-1:0]  sel_ff;
   logic              hit_ff, free_found_ff, moved_ff;
   logic [IDX_W-1:0]  hit_idx_ff, free_idx_ff;
   logic [ADDR_W-1:0] hit_base_ff;
   logic [SIZE_W-1:0] hit_size_ff;
   logic [SIZE_W:0]   cand_ff;
   logic [CNT_W-1:0]  dels_ff;

   logic [2:0]        status_in;
   logic [ADDR_W-1:0] addr_in;
   logic [SIZE_W-1:0] length_in;
   logic [IDX_W-1:0]  ent_in;
   logic [KEY_W-1:0]  app_out_in, var_out_in;

   logic [KEY_W-1:0]  rd_app, rd_var;
   logic [ADDR_W-1:0] rd_base;
   logic [SIZE_W-1:0] rd_size;
   logic              rd_used, app_hit, var_hit;
   logic [SIZE_W:0]   need, rd_end;
   logic [SUM_W-1:0]  cand_top;
   logic [SIZE_W:0]   hit_end, hit_skip_end;

   assign rd_app   = app_mem[cmd.idx];
   assign rd_var   = var_mem[cmd.idx];
   assign rd_base  = base_mem[cmd.idx];
   assign rd_size  = size_mem[cmd.idx];
   assign rd_used  = (rd_size != '0);
   assign app_hit  = names_match(rd_app, app_ff);
   assign var_hit  = names_match(rd_var, var_ff);
   assign need     = {1'b0, len_ff} + {1'b0, skip_ff};
   assign rd_end   = {2'b0, rd_base} + {1'b0, rd_size};
   assign cand_top = {1'b0, cand_ff} + {1'b0, need};
   assign hit_end      = {2'b0, hit_base_ff} + {1'b0, hit_size_ff};
   assign hit_skip_end = {2'b0, hit_base_ff} + {1'b0, skip_ff};

   assign stat.op         = op_ff;
   assign stat.hit        = hit_ff;
   assign stat.need_zero  = (need == '0);
   assign stat.no_space   = (cand_top > SUM_W'(STORE_BYTES));
   assign stat.moved      = moved_ff;
   assign stat.free_found = free_found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            app_mem[i]  <= '0;
            var_mem[i]  <= '0;
            base_mem[i] <= '0;
            size_mem[i] <= '0;
         end
      end else if (cmd.erase) begin
         for (int i = 0; i < ENTRIES; i++) begin
            app_mem[i]  <= '0;
            var_mem[i]  <= '0;
            base_mem[i] <= '0;
            size_mem[i] <= '0;
         end
      end else if (cmd.write_new) begin
         app_mem[free_idx_ff]  <= trim_name(app_ff);
         var_mem[free_idx_ff]  <= trim_name(var_ff);
         base_mem[free_idx_ff] <= cand_ff[ADDR_W-1:0];
         size_mem[free_idx_ff] <= need[SIZE_W-1:0];
      end else if (cmd.del_step && rd_used && app_hit
                   && (op_ff == OP_DEL_APP || var_hit)) begin
         size_mem[cmd.idx] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff         <= req_opcode;
         app_ff        <= req_app_key;
         var_ff        <= req_var_key;
         len_ff        <= req_write_len;
         skip_ff       <= req_write_skip;
         sel_ff        <= req_entry_select;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         dels_ff       <= '0;
         cand_ff       <= '0;
      end
      if (cmd.find_step) begin
         if (rd_used && app_hit && var_hit && !hit_ff) begin
            hit_ff      <= 1'b1;
            hit_idx_ff  <= cmd.idx;
            hit_base_ff <= rd_base;
            hit_size_ff <= rd_size;
         end
         if (!rd_used && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= cmd.idx;
         end
      end
      if (cmd.fit_init) moved_ff <= 1'b0;
      if (cmd.fit_step && rd_used && ({3'b0, rd_base} < cand_top)
          && (cand_ff < rd_end)) begin
         cand_ff  <= rd_end;
         moved_ff <= 1'b1;
      end
      if (cmd.del_step && rd_used && app_hit && (op_ff == OP_DEL_APP || var_hit))
         dels_ff <= dels_ff + 1'b1;
      if (cmd.finish) begin
         rsp_status        <= status_in;
         rsp_byte_address  <= addr_in;
         rsp_length        <= length_in;
         rsp_deleted_count <= dels_ff;
         rsp_entry_number  <= ent_in;
         rsp_app_key_out   <= app_out_in;
         rsp_var_key_out   <= var_out_in;
      end
   end

   always_comb begin
      status_in  = ST_OK;
      addr_in    = '0;
      length_in  = '0;
      ent_in     = '0;
      app_out_in = '0;
      var_out_in = '0;
      case (op_ff)
         OP_GET, OP_SET: begin
            if (hit_ff) begin
               ent_in = hit_idx_ff;
               if (hit_end > (SIZE_W+1)'(STORE_BYTES) || (op_ff == OP_SET
                   && hit_skip_end > (SIZE_W+1)'(STORE_BYTES))) begin
                  status_in = ST_BOGUS;
               end else if (op_ff == OP_GET) begin
                  addr_in   = hit_base_ff;
                  length_in = hit_size_ff;
               end else if (len_ff > hit_size_ff) begin
                  status_in = ST_TOO_LARGE;
               end else begin
                  addr_in   = hit_skip_end[ADDR_W-1:0];
                  length_in = len_ff;
               end
            end else if (op_ff == OP_GET) begin
               status_in = ST_NOT_FOUND;
            end else if (stat.need_zero) begin
               status_in = ST_NO_ENTRY;
            end else if (stat.no_space) begin
               status_in = ST_NO_SPACE;
            end else if (!free_found_ff) begin
               status_in = ST_NO_ENTRY;
            end else begin
               addr_in   = cand_ff[ADDR_W-1:0] + skip_ff[ADDR_W-1:0];
               length_in = len_ff;
               ent_in    = free_idx_ff;
            end
         end
         OP_DEL_VAR, OP_DEL_APP: begin
            if (dels_ff == '0) status_in = ST_NOT_FOUND;
         end
         OP_ERASE: status_in = ST_OK;
         OP_ENUM: begin
            if (sel_ff >= SEL_W'(ENTRIES)) begin
               status_in = ST_RANGE;
            end else begin
               app_out_in = rd_app;
               var_out_in = rd_var;
               length_in  = rd_size;
               ent_in     = sel_ff[IDX_W-1:0];
            end
         end
         default: status_in = ST_RANGE;
      endcase
   end

endmodule

@@ src/named_store_directory.sv @@
// Top level of the named store directory: joins controller and datapath.
// Depends on nsd_pkg, nsd_ctrl and nsd_dpath.
//
// Use: drive the req_ fields and raise start while busy is low; the request
// is taken at that edge and busy rises. One result per request is registered
// onto the rsp_ ports, with rsp_strobe high for exactly one cycle; busy is low
// in that cycle, so a new request may be taken at the same edge.
// From the edge that takes the request to the edge that takes the result:
// enumerate, erase and unknown codes go from dispatch straight to finish;
// both deletes add one table scan; get, set of an existing name and set of
// zero bytes add a find scan and its check; set of a new name also adds one
// first-fit pass per placement candidate tried (at most one more than the
// entry count), each pass stepping through all 16 entries one per cycle over
// the single table read port. Reset clears the whole table (all entries free)
// and the controller. The receiver cannot stall; rsp_ values stay until replaced.
module named_store_directory (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [2:0]                 req_opcode,
   input  logic [nsd_pkg::KEY_W-1:0]  req_app_key,
   input  logic [nsd_pkg::KEY_W-1:0]  req_var_key,
   input  logic [nsd_pkg::SIZE_W-1:0] req_write_len,
   input  logic [nsd_pkg::SIZE_W-1:0] req_write_skip,
   input  logic [nsd_pkg::SEL_W-1:0]  req_entry_select,
   output logic                       rsp_strobe,
   output logic [2:0]                 rsp_status,
   output logic [nsd_pkg::ADDR_W-1:0] rsp_byte_address,
   output logic [nsd_pkg::SIZE_W-1:0] rsp_length,
   output logic [nsd_pkg::CNT_W-1:0]  rsp_deleted_count,
   output logic [nsd_pkg::IDX_W-1:0]  rsp_entry_number,
   output logic [nsd_pkg::KEY_W-1:0]  rsp_app_key_out,
   output logic [nsd_pkg::KEY_W-1:0]  rsp_var_key_out
);
   import nsd_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   nsd_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_entry_select (req_entry_select),
      .stat             (stat),
      .cmd              (cmd),
      .busy             (busy),
      .rsp_strobe       (rsp_strobe)
   );

   nsd_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_opcode),
      .req_app_key       (req_app_key),
      .req_var_key       (req_var_key),
      .req_write_len     (req_write_len),
      .req_write_skip    (req_write_skip),
      .req_entry_select  (req_entry_select),
      .rsp_status        (rsp_status),
      .rsp_byte_address  (rsp_byte_address),
      .rsp_length        (rsp_length),
      .rsp_deleted_count (rsp_deleted_count),
      .rsp_entry_number  (rsp_entry_number),
      .rsp_app_key_out   (rsp_app_key_out),
      .rsp_var_key_out   (rsp_var_key_out)
   );

endmodule
